// ===== hdl/mtte_pkg.sv =====
package mtte_pkg;

  localparam int unsigned Prescale  = 16;
  localparam int unsigned PrescaleW = $clog2(Prescale);
  localparam logic [PrescaleW-1:0] PrescaleMax = PrescaleW'(Prescale - 1);

  // time counter is pulled back by this much on a compare hit
  localparam logic [31:0] Rollback = 32'(10000000 / 10000);

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_WR_TIME = 2'd1,
    FUNC_WR_CMP = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic {
    CFG_TRAP_VECTOR = 1'b0,
    CFG_TIMER_IE    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] write_value;
    logic [31:0] current_pc;
    logic        global_enable_in;
  } item_t;

  typedef struct packed {
    logic        trap_taken;
    logic [31:0] next_pc;
    logic [31:0] saved_pc;
    logic        global_enable_out;
    logic        timer_pending;
    logic [31:0] time_now;
    logic [31:0] time_register;
  } result_t;

  typedef struct packed {
    logic we;
    logic idx;
  } cfg_ctl_t;

endpackage

// ===== hdl/machine_timer_trap_entry_unit.sv =====
// Machine timer with timer-interrupt trap entry. Each item is a tick (func 0),
// a write of the time counter (func 1), a write of the compare value (func 2)
// or a no-op (func 3); every item yields exactly one result. One item is taken
// per clock while the output is not stalled: an input register feeds the
// timer/trap logic, which updates the timer state and loads the result
// register; the result is held there until taken when the output is stalled.
// Every 16th tick advances the time counter and the free-running time register;
// a compare hit sets the sticky pending flag and pulls the time counter back by
// 1000. Configure trap_vector (index 0) and timer_int_enable (index 1) only
// while no item is in flight.
module machine_timer_trap_entry_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] write_value_i,
  input  logic [31:0] current_pc_i,
  input  logic        global_enable_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        trap_taken_o,
  output logic [31:0] next_pc_o,
  output logic [31:0] saved_pc_o,
  output logic        global_enable_out_o,
  output logic        timer_pending_o,
  output logic [31:0] time_now_o,
  output logic [31:0] time_register_o
);

  mtte_pkg::item_t    in_item, item;
  mtte_pkg::result_t  res;
  mtte_pkg::cfg_ctl_t cfg_ctl;
  logic               item_valid, adv;

  assign in_item.func             = func_i;
  assign in_item.write_value      = write_value_i;
  assign in_item.current_pc       = current_pc_i;
  assign in_item.global_enable_in = global_enable_in_i;

  assign cfg_ctl.we  = cfg_we_i;
  assign cfg_ctl.idx = cfg_index_i;

  mtte_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item),
    .in_stall_o   (in_stall_o),
    .adv_i        (adv),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mtte_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_ctl_i    (cfg_ctl),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_stall_i  (out_stall_i),
    .adv_o        (adv),
    .out_valid_o  (out_valid_o),
    .result_o     (res)
  );

  assign trap_taken_o        = res.trap_taken;
  assign next_pc_o           = res.next_pc;
  assign saved_pc_o          = res.saved_pc;
  assign global_enable_out_o = res.global_enable_out;
  assign timer_pending_o     = res.timer_pending;
  assign time_now_o          = res.time_now;
  assign time_register_o     = res.time_register;

endmodule

// ===== hdl/mtte_in_stage.sv =====
module mtte_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  mtte_pkg::item_t in_item_i,
  output logic            in_stall_o,
  input  logic            adv_i,
  output logic            item_valid_o,
  output mtte_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  mtte_pkg::item_t item_q;
  logic            load;

  // the stage may take a new item when empty or when its item moves on
  assign load       = adv_i || !valid_q;
  assign in_stall_o = !load;
  assign valid_d    = load ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== hdl/mtte_core.sv =====
module mtte_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mtte_pkg::cfg_ctl_t cfg_ctl_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              item_valid_i,
  input  mtte_pkg::item_t   item_i,
  input  logic              out_stall_i,
  output logic              adv_o,
  output logic              out_valid_o,
  output mtte_pkg::result_t result_o
);

  logic [31:0] trap_vector_q;
  logic        timer_ie_q;
  logic [mtte_pkg::PrescaleW-1:0] prescale_q, prescale_d;
  logic [31:0] time_q, time_d;
  logic [31:0] mirror_q, mirror_d;
  logic [31:0] cmp_q, cmp_d;
  logic        pend_q, pend_d;
  logic        out_valid_q;
  mtte_pkg::result_t res_q, res_d;

  logic        fire, wrap, hit, taken;
  logic [31:0] time_inc;

  assign adv_o = !out_valid_q || !out_stall_i;
  assign fire  = adv_o && item_valid_i;

  assign wrap     = (prescale_q == mtte_pkg::PrescaleMax);
  assign time_inc = time_q + 32'd1;
  assign hit      = (cmp_q != 32'd0) && (time_inc >= cmp_q);

  always_comb begin
    prescale_d = prescale_q;
    time_d     = time_q;
    mirror_d   = mirror_q;
    cmp_d      = cmp_q;
    pend_d     = pend_q;
    taken      = 1'b0;
    case (item_i.func)
      mtte_pkg::FUNC_TICK: begin
        if (!wrap) begin
          prescale_d = prescale_q + 1'b1;
        end else begin
          prescale_d = '0;
          mirror_d   = mirror_q + 32'd1;
          time_d     = hit ? (time_inc - mtte_pkg::Rollback) : time_inc;
          pend_d     = pend_q || hit;
          if (pend_d && timer_ie_q && item_i.global_enable_in) begin
            taken  = 1'b1;
            pend_d = 1'b0;
          end
        end
      end
      mtte_pkg::FUNC_WR_TIME: time_d = item_i.write_value;
      mtte_pkg::FUNC_WR_CMP:  cmp_d  = item_i.write_value;
      default: ;
    endcase

    res_d.trap_taken        = taken;
    res_d.next_pc           = taken ? trap_vector_q : item_i.current_pc;
    res_d.saved_pc          = taken ? item_i.current_pc : 32'd0;
    res_d.global_enable_out = item_i.global_enable_in && !taken;
    res_d.timer_pending     = pend_d;
    res_d.time_now          = time_d;
    res_d.time_register     = mirror_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trap_vector_q <= '0;
      timer_ie_q    <= 1'b0;
      prescale_q    <= '0;
      time_q        <= '0;
      mirror_q      <= '0;
      cmp_q         <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_ctl_i.we) begin
        case (cfg_ctl_i.idx)
          mtte_pkg::CFG_TRAP_VECTOR: trap_vector_q <= cfg_wdata_i;
          mtte_pkg::CFG_TIMER_IE:    timer_ie_q    <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (fire) begin
        prescale_q <= prescale_d;
        time_q     <= time_d;
        mirror_q   <= mirror_d;
        cmp_q      <= cmp_d;
        pend_q     <= pend_d;
      end
      if (adv_o) begin
        out_valid_q <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule
